// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands shared by the rtl, clocked on aclk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PMC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// checked on every edge, reset included
`define PMC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

// File: rtl/pmc_pkg.sv
// ----------------------------------------------------------------------------
// pmc_pkg
// widths and constants of the prefix max chain engine
// ----------------------------------------------------------------------------
package pmc_pkg;

    // leaves of the max tree, power of two
    localparam int LEAVES     = 1024;
    localparam int LEAF_W     = $clog2(LEAVES);
    localparam int NODE_W     = LEAF_W + 1;          // tree node address
    localparam int HI_W       = NODE_W + 1;          // query bound, reaches 2*LEAVES
    localparam int TREE_DEPTH = 2 * LEAVES;

    localparam int COL_W      = 10;
    localparam int WT_W       = 32;
    localparam int VAL_W      = 48;

    localparam int S_TDATA_W  = ((COL_W + WT_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((2 * VAL_W + 7) / 8) * 8;

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

endpackage

// File: rtl/prefix_max_chain_dp.sv
// ----------------------------------------------------------------------------
// prefix_max_chain_dp
// maximum-weight monotone chain engine built around a max tree in one ram
// ----------------------------------------------------------------------------
// usage:
// - s_ channel takes one word per point in sweep order: column and weight
// - m_ channel returns one word per point: chain value and running best
// - chain value = saturated (max over leaves 0..column) + weight, then written
//   to the column's leaf; the node maxima up to the root are refreshed
// - one point at a time; the single tree ram read port sets the pace: the
//   query reads one node per level, the update reads one sibling per level;
//   the query walk ends early for low columns
// - the next point is taken only after the result is registered, so the
//   walks of two points never overlap
// - a finished word waits in the output register; the next point is taken
//   while it waits, and the engine holds a second result until it is taken
// - after reset the ram is cleared one node a cycle over all of its nodes,
//   with s_tready low; the running best resets to zero
// ----------------------------------------------------------------------------
module prefix_max_chain_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input words
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pmc_pkg::S_TDATA_W-1:0]  s_tdata,   // column[9:0], weight[41:10]
    // result words
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pmc_pkg::M_TDATA_W-1:0]  m_tdata    // chain_value[47:0], best_so_far[95:48]
);

    import pmc_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUERY,
        ST_SUM,
        ST_LEAF,
        ST_CLIMB,
        ST_DONE
    } state_t;

    // control
    state_t              state_reg, state_next;
    logic [NODE_W-1:0]   clr_reg, clr_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [VAL_W-1:0]    best_reg, best_next;
    // working payload
    logic [NODE_W-1:0]   lo_reg, lo_next;
    logic [HI_W-1:0]     hi_reg, hi_next;
    logic                pend_reg, pend_next;
    logic [VAL_W-1:0]    acc_reg, acc_next;
    logic [WT_W-1:0]     weight_reg, weight_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [VAL_W-1:0]    val_reg, val_next;
    logic [VAL_W-1:0]    chain_reg, chain_next;
    logic [VAL_W-1:0]    m_chain_reg, m_chain_next;
    logic [VAL_W-1:0]    m_best_reg, m_best_next;

    // tree ram port
    logic                ram_we;
    logic [NODE_W-1:0]   ram_waddr;
    logic [VAL_W-1:0]    ram_wdata;
    logic [NODE_W-1:0]   ram_raddr;
    logic [VAL_W-1:0]    ram_rdata;

    logic [COL_W-1:0]    in_col;
    logic [WT_W-1:0]     in_weight;
    logic [NODE_W-1:0]   in_leaf;
    logic [VAL_W:0]      sum;
    logic [NODE_W-1:0]   parent;
    logic [VAL_W-1:0]    up_val;
    logic [VAL_W-1:0]    best_cand;

    assign in_col    = s_tdata[COL_W-1:0];
    assign in_weight = s_tdata[COL_W+WT_W-1:COL_W];
    // leaf node = LEAVES + (column mod LEAVES)
    assign in_leaf   = {1'b1, LEAF_W'(in_col)};

    assign sum       = {1'b0, acc_reg} + (VAL_W+1)'(weight_reg);
    assign parent    = node_reg >> 1;
    // parent max from the climbing value and the sibling just read
    assign up_val    = (ram_rdata > val_reg) ? ram_rdata : val_reg;
    // val_reg holds the climbing max, chain_reg keeps the point's own value
    assign best_cand = (chain_reg > best_reg) ? chain_reg : best_reg;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {m_best_reg, m_chain_reg};

    pmc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TREE_DEPTH)
    ) u_tree (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        m_tvalid_next = m_tvalid_reg;
        best_next     = best_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        pend_next     = 1'b0;
        acc_next      = acc_reg;
        weight_next   = weight_reg;
        node_next     = node_reg;
        val_next      = val_reg;
        chain_next    = chain_reg;
        m_chain_next  = m_chain_reg;
        m_best_next   = m_best_reg;

        ram_we    = 1'b0;
        ram_waddr = node_reg;
        ram_wdata = val_reg;
        ram_raddr = lo_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                // zero one node per cycle
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + NODE_W'(1);
                if (clr_reg == {NODE_W{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    weight_next = in_weight;
                    node_next   = in_leaf;
                    lo_next     = NODE_W'(LEAVES);
                    hi_next     = HI_W'(in_leaf) + HI_W'(1);
                    acc_next    = '0;
                    state_next  = ST_QUERY;
                end
            end
            ST_QUERY: begin
                // fold in the node read last cycle
                if (pend_reg && (ram_rdata > acc_reg)) begin
                    acc_next = ram_rdata;
                end
                if (HI_W'(lo_reg) < hi_reg) begin
                    // left bound is odd only at the root
                    if (lo_reg[0]) begin
                        ram_raddr = lo_reg;
                        pend_next = 1'b1;
                    end else if (hi_reg[0]) begin
                        ram_raddr = NODE_W'(hi_reg - HI_W'(1));
                        pend_next = 1'b1;
                    end
                    lo_next = NODE_W'((HI_W'(lo_reg) + HI_W'(lo_reg[0])) >> 1);
                    hi_next = (hi_reg - HI_W'(hi_reg[0])) >> 1;
                end else begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                val_next   = sum[VAL_W] ? VAL_MAX : sum[VAL_W-1:0];
                chain_next = val_next;
                state_next = ST_LEAF;
            end
            ST_LEAF: begin
                ram_we     = 1'b1;
                ram_waddr  = node_reg;
                ram_wdata  = val_reg;
                ram_raddr  = {node_reg[NODE_W-1:1], ~node_reg[0]};
                state_next = ST_CLIMB;
            end
            ST_CLIMB: begin
                ram_we    = 1'b1;
                ram_waddr = parent;
                ram_wdata = up_val;
                ram_raddr = {parent[NODE_W-1:1], ~parent[0]};
                val_next  = up_val;
                node_next = parent;
                if (parent == NODE_W'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_chain_next  = chain_reg;
                    m_best_next   = best_cand;
                    best_next     = best_cand;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            best_reg     <= '0;
            pend_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
            best_reg     <= best_next;
            pend_reg     <= pend_next;
        end
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        acc_reg     <= acc_next;
        weight_reg  <= weight_next;
        node_reg    <= node_next;
        val_reg     <= val_next;
        chain_reg   <= chain_next;
        m_chain_reg <= m_chain_next;
        m_best_reg  <= m_best_next;
    end

`include "assert_macros.svh"

    `PMC_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid && state_reg == ST_CLEAR, "reset did not restart clear")
    `PMC_ASSERT(a_best_covers_chain, m_tvalid |-> m_best_reg >= m_chain_reg, "best below chain value")
    `PMC_ASSERT(a_best_monotone, $past(aresetn) |-> best_reg >= $past(best_reg), "running best dropped")
    `PMC_ASSERT(a_no_node0_write, ram_we && state_reg != ST_CLEAR |-> ram_waddr != '0, "write to unused node")

endmodule

// File: rtl/pmc_ram.sv
// ----------------------------------------------------------------------------
// pmc_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module pmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: test/prefix_max_chain_dp_tb.sv
// ----------------------------------------------------------------------------
// prefix_max_chain_dp_tb
// self-checking bench for the prefix max chain engine
// ----------------------------------------------------------------------------
// every accepted point runs through a local copy of the max tree, which gives
// the chain value and running best that the engine must return. a short table
// of directed points comes first, then rows of ascending columns with random
// weights, a back-pressure stretch, and a short burst of full weights on the
// top column. both channels idle at random
// ----------------------------------------------------------------------------
module prefix_max_chain_dp_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pmc_pkg::*;

    localparam int RANDOM_POINTS = 2000;
    localparam int HOLD_CYCLES   = 400;     // long receiver stall
    localparam int WATCHDOG_MAX  = 10000;   // cycles without any word moving
    localparam int TAIL_CYCLES   = 60;      // settle time after last result
    localparam int MAX_PRINTS    = 40;
    localparam int BURST_POINTS  = 16;      // full weight points on the top column

    // expected word on the result channel
    typedef struct packed {
        logic [VAL_W-1:0] chain;
        logic [VAL_W-1:0] best;
    } chain_result_t;

    // one directed point; typed results only where obvious
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [WT_W-1:0]  wt;
        bit               typed;
        logic [VAL_W-1:0] chain;
        logic [VAL_W-1:0] best;
    } point_row_t;

    localparam logic [WT_W-1:0] WT_MAX = {WT_W{1'b1}};
    localparam logic [COL_W-1:0] COL_TOP = {COL_W{1'b1}};

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // local copy of the engine state
    logic [VAL_W-1:0] chain_tree [TREE_DEPTH];
    logic [VAL_W-1:0] tree_best;

    chain_result_t chain_results_q [$];

    int  err_count   = 0;
    int  idle_cycles = 0;
    int  stall_left  = 0;
    int  hold_left   = 0;
    bit  hold_req    = 0;   // sender asks the receiver for a long stall
    bit  no_idle     = 0;   // both sides run flat out

    // directed points: extremes, leaf overwrite, alternating bit patterns
    point_row_t point_table [17] = '{
        '{10'd0,    32'd0,        1'b1, 48'd0,          48'd0},          // fresh tree
        '{COL_TOP,  WT_MAX,       1'b1, 48'hFFFF_FFFF,  48'hFFFF_FFFF},  // top column
        '{10'd0,    32'd1,        1'b1, 48'd1,          48'hFFFF_FFFF},
        '{10'd0,    32'd1,        1'b1, 48'd2,          48'hFFFF_FFFF},  // overwrite leaf
        '{10'd1,    32'd0,        1'b1, 48'd2,          48'hFFFF_FFFF},  // zero weight
        '{COL_TOP,  WT_MAX,       1'b0, 48'd0,          48'd0},
        '{10'd1022, 32'hAAAA_AAAA, 1'b0, 48'd0,         48'd0},
        '{10'h155,  32'h5555_5555, 1'b0, 48'd0,         48'd0},
        '{10'h2AA,  32'hAAAA_AAAA, 1'b0, 48'd0,         48'd0},
        '{10'd512,  32'd100,      1'b0, 48'd0,          48'd0},
        '{10'd511,  32'h8000_0000, 1'b0, 48'd0,         48'd0},
        '{10'd513,  32'd0,        1'b0, 48'd0,          48'd0},
        '{10'd1,    WT_MAX,       1'b0, 48'd0,          48'd0},
        '{10'd1022, 32'd1,        1'b0, 48'd0,          48'd0},
        '{COL_TOP,  32'd0,        1'b0, 48'd0,          48'd0},
        '{10'd2,    32'h1234_5678, 1'b0, 48'd0,         48'd0},
        '{COL_TOP,  32'd1,        1'b0, 48'd0,          48'd0}
    };

    prefix_max_chain_dp u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // column[9:0], weight[41:10]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // chain_value[47:0], best_so_far[95:48]
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // largest chain value stored over leaves 0..col, walking the tree upward
    function automatic logic [VAL_W-1:0] prefix_peak(input logic [COL_W-1:0] col);
        int unsigned      lft;
        int unsigned      rgt;
        logic [VAL_W-1:0] peak;
        lft  = LEAVES;
        rgt  = LEAVES + (int'(col) % LEAVES) + 1;
        peak = '0;
        while (lft < rgt) begin
            if (lft[0]) begin
                if (chain_tree[NODE_W'(lft)] > peak) peak = chain_tree[NODE_W'(lft)];
                lft++;
            end
            if (rgt[0]) begin
                rgt--;
                if (chain_tree[NODE_W'(rgt)] > peak) peak = chain_tree[NODE_W'(rgt)];
            end
            lft >>= 1;
            rgt >>= 1;
        end
        return peak;
    endfunction

    // score one point, store it in its leaf and refresh the path to the root
    task automatic score_point(input logic [COL_W-1:0] col, input logic [WT_W-1:0] wt,
                               output chain_result_t res);
        logic [VAL_W:0]   sum;
        logic [VAL_W-1:0] val;
        int unsigned      node;
        sum = {1'b0, prefix_peak(col)} + {{(VAL_W+1-WT_W){1'b0}}, wt};
        val = sum[VAL_W] ? VAL_MAX : sum[VAL_W-1:0];   // saturate
        node = LEAVES + (int'(col) % LEAVES);
        chain_tree[NODE_W'(node)] = val;
        node >>= 1;
        while (node > 0) begin
            chain_tree[NODE_W'(node)] =
                (chain_tree[NODE_W'(2*node)] > chain_tree[NODE_W'(2*node+1)]) ?
                chain_tree[NODE_W'(2*node)] : chain_tree[NODE_W'(2*node+1)];
            node >>= 1;
        end
        if (val > tree_best) tree_best = val;
        res.chain = val;
        res.best  = tree_best;
    endtask

    initial begin
        for (int i = 0; i < TREE_DEPTH; i++) chain_tree[NODE_W'(i)] = '0;
        tree_best = '0;
    end

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    endtask

    task automatic check_word(input logic [M_TDATA_W-1:0] word);
        chain_result_t want;
        if (chain_results_q.size() == 0) begin
            report_mismatch("unexpected word", word[VAL_W-1:0], '0);
        end else begin
            want = chain_results_q.pop_front();
            if (word[VAL_W-1:0] !== want.chain)
                report_mismatch("chain_value", word[VAL_W-1:0], want.chain);
            if (word[2*VAL_W-1:VAL_W] !== want.best)
                report_mismatch("best_so_far", word[2*VAL_W-1:VAL_W], want.best);
        end
    endtask

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side: take words, stall at random, long hold on request
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_word(m_tdata);
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog: no word moving on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("watchdog: no word moved in %0d cycles", WATCHDOG_MAX);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    // drop valid for a gap of length n; with n zero valid stays up for the next word
    task automatic idle_for(input int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // offer one point, wait for the handshake, then queue its expected word
    task automatic send_point(input logic [COL_W-1:0] col, input logic [WT_W-1:0] wt,
                              input bit typed, input chain_result_t typed_res);
        chain_result_t res;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-COL_W-WT_W){1'b0}}, wt, col};
        do @(posedge aclk); while (!s_tready);
        score_point(col, wt, res);
        chain_results_q.insert(chain_results_q.size(), typed ? typed_res : res);
    endtask

    task automatic wait_drained();
        idle_for(1);
        while (chain_results_q.size() != 0) @(posedge aclk);
    endtask

    // mostly small weights, some wide, a few at the extremes
    function automatic logic [WT_W-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return $urandom_range(0, 255);
        if (r < 75) return $urandom_range(0, 1 << 20);
        if (r < 95) return $urandom;
        return (r < 98) ? WT_MAX : '0;
    endfunction

    // sweep rows of ascending columns, with a few stray points as noise
    task automatic send_rows(input int n_points);
        int               sent;
        int               row_len;
        int               col;
        chain_result_t    none;
        none = '0;
        sent = 0;
        while (sent < n_points) begin
            if ($urandom_range(0, 9) == 0) begin
                idle_for(pick_gap());
                send_point(COL_W'($urandom_range(0, 1023)), pick_weight(), 1'b0, none);
                sent++;
            end else begin
                row_len = $urandom_range(1, 16);
                col     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                       : $urandom_range(0, 63);
                for (int i = 0; i < row_len && sent < n_points; i++) begin
                    idle_for(pick_gap());
                    send_point(COL_W'(col), pick_weight(), 1'b0, none);
                    sent++;
                    col += $urandom_range(0, 64);
                    if (col > 1023) col = 1023;
                end
            end
        end
    endtask

    initial begin
        chain_result_t none;
        chain_result_t typed_res;
        none = '0;

        // hold reset first; after release the engine clears its tree ram
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (point_table[i]) begin
            typed_res.chain = point_table[i].chain;
            typed_res.best  = point_table[i].best;
            idle_for(pick_gap());
            send_point(point_table[i].col, point_table[i].wt, point_table[i].typed,
                       typed_res);
        end
        wait_drained();

        // random rows with idling on both sides
        send_rows(RANDOM_POINTS / 2);
        wait_drained();

        // a stretch with no idling at all
        no_idle = 1;
        send_rows(RANDOM_POINTS / 4);
        no_idle = 0;

        // hold the result side while points keep coming, so the input stalls
        hold_req = 1;
        for (int i = 0; i < 10; i++) send_point(COL_W'($urandom_range(0, 1023)),
                                                pick_weight(), 1'b0, none);
        send_rows(RANDOM_POINTS / 4);
        wait_drained();

        // full weights on the top column, then a low and a high column behind it
        no_idle = 1;
        for (int i = 0; i < BURST_POINTS; i++) send_point(COL_TOP, WT_MAX, 1'b0, none);
        send_point(10'd0, 32'd5, 1'b0, none);
        send_point(10'd1022, WT_MAX, 1'b0, none);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/pmc_pkg.sv
rtl/pmc_ram.sv
rtl/prefix_max_chain_dp.sv
test/prefix_max_chain_dp_tb.sv
